FILE: src/mrlp_pkg.sv
// Package for the modem response line parser: parse states, status codes,
// character constants and the per-byte result record. No dependencies.
package mrlp_pkg;

    localparam int LINE_W = 3;
    localparam int COL_W  = 7;

    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_R    = 8'h52;

    typedef enum logic [4:0] {
        ST_WAIT_CR    = 5'd0,
        ST_WAIT_LF    = 5'd1,
        ST_HEAD       = 5'd2,
        ST_OK_K       = 5'd3,
        ST_END_CR     = 5'd4,
        ST_END_LF     = 5'd5,
        ST_DONE       = 5'd6,
        ST_ERR_R1     = 5'd7,
        ST_ERR_R2     = 5'd8,
        ST_ERR_O      = 5'd9,
        ST_ERR_R3     = 5'd10,
        ST_ERR_CR     = 5'd11,
        ST_PLUS_FIRST = 5'd12,
        ST_PLUS_BODY  = 5'd13,
        ST_PLUS_LF    = 5'd14,
        ST_AFTER_PLUS = 5'd15,
        ST_BLANK_LF   = 5'd16,
        ST_FINAL      = 5'd17
    } state_t;

    typedef enum logic [1:0] {
        STAT_FEED     = 2'd0,
        STAT_END      = 2'd1,
        STAT_GRAMMAR  = 2'd2,
        STAT_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic                store_write;
        logic [LINE_W-1:0]   store_line;
        logic [COL_W-1:0]    store_column;
        logic [7:0]          store_char;
        logic                line_done;
        logic                clear_store;
    } result_t;

endpackage

FILE: src/mrlp_fsm.sv
// Parse state machine with line and column counters; one transition per byte.
// Depends on mrlp_pkg.
module mrlp_fsm #(
    parameter int NUM_LINES = 8,
    parameter int LINE_LEN  = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        rx_byte,
    output mrlp_pkg::result_t result
);

    localparam int LW = $clog2(NUM_LINES + 1);
    localparam int CW = $clog2(LINE_LEN + 1);

    mrlp_pkg::state_t  state_reg, state_next;
    logic [LW-1:0]     line_reg, line_next;
    logic [CW-1:0]     col_reg, col_next;

    mrlp_pkg::state_t  acc_state;
    mrlp_pkg::status_t acc_stat;
    logic              acc, closes, bad, restart_req, overflow, is_crlf;
    logic [LW-1:0]     eff_line;
    logic [CW-1:0]     eff_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrlp_pkg::ST_WAIT_CR;
            line_reg  <= '0;
            col_reg   <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
        end
    end

    always_comb begin
        acc         = 1'b0;
        closes      = 1'b0;
        bad         = 1'b0;
        restart_req = 1'b0;
        acc_state   = mrlp_pkg::ST_WAIT_CR;
        acc_stat    = mrlp_pkg::STAT_FEED;
        is_crlf     = (rx_byte == mrlp_pkg::CH_CR) || (rx_byte == mrlp_pkg::CH_LF);

        unique case (state_reg)
            mrlp_pkg::ST_WAIT_LF: begin
                if (rx_byte == mrlp_pkg::CH_LF) begin
                    acc = 1'b1; closes = 1'b1; acc_state = mrlp_pkg::ST_HEAD;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_HEAD: begin
                if (rx_byte == mrlp_pkg::CH_O) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_OK_K;
                end else if (rx_byte == mrlp_pkg::CH_E) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_ERR_R1;
                end else if (rx_byte == mrlp_pkg::CH_PLUS) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_PLUS_FIRST;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_OK_K: begin
                if (rx_byte == mrlp_pkg::CH_K) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_END_CR;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_END_CR: begin
                if (rx_byte == mrlp_pkg::CH_CR) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_END_LF;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_END_LF: begin
                if (rx_byte == mrlp_pkg::CH_LF) begin
                    acc = 1'b1; closes = 1'b1; acc_state = mrlp_pkg::ST_DONE;
                    acc_stat = mrlp_pkg::STAT_END;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_DONE: begin
                restart_req = 1'b1;
                if (rx_byte == mrlp_pkg::CH_CR) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_WAIT_LF;
                end
            end
            mrlp_pkg::ST_ERR_R1: begin
                if (rx_byte == mrlp_pkg::CH_R) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_ERR_R2;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_ERR_R2: begin
                if (rx_byte == mrlp_pkg::CH_R) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_ERR_O;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_ERR_O: begin
                if (rx_byte == mrlp_pkg::CH_O) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_ERR_R3;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_ERR_R3: begin
                if (rx_byte == mrlp_pkg::CH_R) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_ERR_CR;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_ERR_CR: begin
                if (rx_byte == mrlp_pkg::CH_CR) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_END_LF;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_PLUS_FIRST: begin
                if (!is_crlf) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_PLUS_BODY;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_PLUS_BODY: begin
                if (!is_crlf) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_PLUS_BODY;
                end else if (rx_byte == mrlp_pkg::CH_CR) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_PLUS_LF;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_PLUS_LF: begin
                if (rx_byte == mrlp_pkg::CH_LF) begin
                    acc = 1'b1; closes = 1'b1; acc_state = mrlp_pkg::ST_AFTER_PLUS;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_AFTER_PLUS: begin
                if (rx_byte == mrlp_pkg::CH_PLUS) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_PLUS_FIRST;
                end else if (rx_byte == mrlp_pkg::CH_CR) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_BLANK_LF;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_BLANK_LF: begin
                if (rx_byte == mrlp_pkg::CH_LF) begin
                    acc = 1'b1; closes = 1'b1; acc_state = mrlp_pkg::ST_FINAL;
                end else bad = 1'b1;
            end
            mrlp_pkg::ST_FINAL: begin
                if (rx_byte == mrlp_pkg::CH_E) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_ERR_R1;
                end else if (rx_byte == mrlp_pkg::CH_O) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_OK_K;
                end else bad = 1'b1;
            end
            default: begin
                if (rx_byte == mrlp_pkg::CH_CR) begin
                    acc = 1'b1; acc_state = mrlp_pkg::ST_WAIT_LF;
                end
            end
        endcase

        eff_line = restart_req ? '0 : line_reg;
        eff_col  = restart_req ? '0 : col_reg;
        overflow = (eff_line >= LW'(NUM_LINES)) || (eff_col >= CW'(LINE_LEN)) ||
                   (closes && ((CW+1)'(eff_col) + (CW+1)'(1) >= (CW+1)'(LINE_LEN)));

        result       = '0;
        state_next   = state_reg;
        line_next    = line_reg;
        col_next     = col_reg;

        if (bad || (acc && overflow)) begin
            result.status      = bad ? mrlp_pkg::STAT_GRAMMAR : mrlp_pkg::STAT_OVERFLOW;
            result.clear_store = 1'b1;
            state_next         = mrlp_pkg::ST_WAIT_CR;
            line_next          = '0;
            col_next           = '0;
        end else if (acc) begin
            result.status       = acc_stat;
            result.store_write  = 1'b1;
            result.store_line   = mrlp_pkg::LINE_W'(eff_line);
            result.store_column = mrlp_pkg::COL_W'(eff_col);
            result.store_char   = rx_byte;
            result.line_done    = closes;
            result.clear_store  = restart_req;
            state_next          = acc_state;
            if (closes) begin
                line_next = eff_line + LW'(1);
                col_next  = '0;
            end else begin
                line_next = eff_line;
                col_next  = eff_col + CW'(1);
            end
        end else if (restart_req) begin
            result.clear_store = 1'b1;
            state_next         = mrlp_pkg::ST_WAIT_CR;
            line_next          = '0;
            col_next           = '0;
        end
    end

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= CW'(LINE_LEN))
        else $error("column counter beyond line length");

    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg <= LW'(NUM_LINES))
        else $error("line counter beyond line count");

    a_err_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.status == mrlp_pkg::STAT_GRAMMAR || result.status == mrlp_pkg::STAT_OVERFLOW)
        |-> (!result.store_write && result.clear_store))
        else $error("error result carries a store write");

    a_err_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && (result.status == mrlp_pkg::STAT_GRAMMAR ||
                     result.status == mrlp_pkg::STAT_OVERFLOW))
        |=> (state_reg == mrlp_pkg::ST_WAIT_CR && line_reg == '0 && col_reg == '0))
        else $error("parser did not restart after error");

    a_done_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.line_done) |-> (result.store_write && result.store_char == mrlp_pkg::CH_LF))
        else $error("line done without a stored LF");

endmodule

FILE: src/modem_response_line_parser_top.sv
// Top level of the modem response line parser: input register, parse FSM,
// result register. Depends on mrlp_pkg and mrlp_fsm.
// An accepted byte passes the input register, then the FSM, then the output register.
// Throughput: one byte per cycle unless the output stalls; state and counters update per byte.
// A stalled result holds in the output register while the input register takes one more byte.
// Reset (aresetn low, synchronous): both registers empty, parser waits for CR, counters zero.
module modem_response_line_parser_top #(
    parameter int NUM_LINES = 8,
    parameter int LINE_LEN  = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic       m_store_write,
    output logic [2:0] m_store_line,
    output logic [6:0] m_store_column,
    output logic [7:0] m_store_char,
    output logic       m_line_done,
    output logic       m_clear_store
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    mrlp_pkg::result_t out_res_reg;
    mrlp_pkg::result_t step_res;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    mrlp_fsm #(
        .NUM_LINES (NUM_LINES),
        .LINE_LEN  (LINE_LEN)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .result  (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_res_reg.status;
    assign m_store_write  = out_res_reg.store_write;
    assign m_store_line   = out_res_reg.store_line;
    assign m_store_column = out_res_reg.store_column;
    assign m_store_char   = out_res_reg.store_char;
    assign m_line_done    = out_res_reg.line_done;
    assign m_clear_store  = out_res_reg.clear_store;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_res_reg)))
        else $error("stalled result changed");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending request dropped");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

endmodule
